>>> sv/psu_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
// Used by psu_ctrl, psu_recon, the top level and the port checker.
`timescale 1ns / 1ps
`default_nettype none

package psu_pkg;

   localparam int BYTE_W   = 8;
   localparam int BPP_W    = 4;
   localparam int LEN_W    = 13;
   localparam int ROWS_W   = 31;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 31;
   localparam int USER_W   = 2;

   // rsp_tuser bit positions
   localparam int USER_IMAGE_END = 0;
   localparam int USER_STATUS    = 1;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_LINE_DATA_BYTES = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_ROW_TOTAL       = 2'd2;

   localparam logic [BYTE_W-1:0] FILTER_LAST_CODE = 8'd4;

   typedef enum logic [2:0] {
      FILTER_NONE    = 3'd0,
      FILTER_SUB     = 3'd1,
      FILTER_UP      = 3'd2,
      FILTER_AVERAGE = 3'd3,
      FILTER_PAETH   = 3'd4
   } psu_filter_type;

   // control info travelling with one byte from the accept stage to reconstruction
   typedef struct packed {
      logic           err;
      logic           first_row;
      logic           row_end;
      logic           image_end;
      psu_filter_type kind;
   } psu_tag_type;

endpackage

`default_nettype wire

>>> sv/psu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module psu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> sv/psu_ctrl.sv
// Accept stage: config registers, row/column counters, filter byte decode,
// line store read issue. Depends on psu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psu_ctrl #(
   parameter int MAX_ROW_BYTES   = 4096,
   parameter int MAX_PIXEL_BYTES = 8,
   localparam int XW   = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
   localparam int COLW = $clog2(MAX_ROW_BYTES + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [psu_pkg::CSR_AW-1:0]   csr_addr,
   input  wire logic [psu_pkg::CSR_DW-1:0]   csr_wdata,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [psu_pkg::BYTE_W-1:0]   req_tdata,
   output logic                              s1_valid,
   output logic      [psu_pkg::BYTE_W-1:0]   s1_byte,
   output logic      [XW-1:0]                s1_x,
   output psu_pkg::psu_tag_type              s1_tag,
   input  wire logic                         s1_take,
   output logic      [psu_pkg::BPP_W-1:0]    bpp,
   output logic                              rd_en,
   output logic      [XW-1:0]                rd_addr
);

   import psu_pkg::*;

   logic [BPP_W-1:0]  cfg_bpp_ff,  cfg_bpp_in;
   logic [LEN_W-1:0]  cfg_len_ff,  cfg_len_in;
   logic [ROWS_W-1:0] cfg_rows_ff, cfg_rows_in;

   logic [COLW-1:0]   column_ff,    column_in;
   logic [ROWS_W-1:0] row_index_ff, row_index_in;
   logic              first_row_ff, first_row_in;
   logic              halted_ff,    halted_in;
   psu_filter_type    kind_ff,      kind_in;

   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff,  s1_byte_in;
   logic [XW-1:0]     s1_x_ff,     s1_x_in;
   psu_tag_type       s1_tag_ff,   s1_tag_in;

   logic [COLW-1:0]   len_eff;
   logic [ROWS_W-1:0] rows_eff;
   logic              s1_free;
   logic              accept;
   logic              row_last;
   logic              image_last;
   logic [XW-1:0]     x_cur;

   // out-of-range registers act as the nearest legal value
   always_comb begin
      if (cfg_bpp_ff == '0) begin
         bpp = BPP_W'(1);
      end else if (32'(cfg_bpp_ff) > MAX_PIXEL_BYTES) begin
         bpp = BPP_W'(MAX_PIXEL_BYTES);
      end else begin
         bpp = cfg_bpp_ff;
      end
      if (cfg_len_ff == '0) begin
         len_eff = COLW'(1);
      end else if (32'(cfg_len_ff) > MAX_ROW_BYTES) begin
         len_eff = COLW'(MAX_ROW_BYTES);
      end else begin
         len_eff = COLW'(cfg_len_ff);
      end
      rows_eff = (cfg_rows_ff == '0) ? ROWS_W'(1) : cfg_rows_ff;
   end

   assign s1_free    = !s1_valid_ff || s1_take;
   // once halted, bytes are taken and dropped
   assign req_tready = halted_ff || s1_free;
   assign accept     = req_tvalid && req_tready && !halted_ff;

   assign x_cur      = XW'(column_ff - COLW'(1));
   assign row_last   = 32'(column_ff) >= 32'(len_eff);
   assign image_last = row_last && ((32'(row_index_ff) + 32'd1) >= 32'(rows_eff));

   assign rd_en   = accept && (column_ff != '0);
   assign rd_addr = x_cur;

   always_comb begin
      cfg_bpp_in   = cfg_bpp_ff;
      cfg_len_in   = cfg_len_ff;
      cfg_rows_in  = cfg_rows_ff;
      column_in    = column_ff;
      row_index_in = row_index_ff;
      first_row_in = first_row_ff;
      halted_in    = halted_ff;
      kind_in      = kind_ff;
      s1_valid_in  = s1_take ? 1'b0 : s1_valid_ff;
      s1_byte_in   = s1_byte_ff;
      s1_x_in      = s1_x_ff;
      s1_tag_in    = s1_tag_ff;

      if (csr_we) begin
         unique case (csr_addr)
            CSR_BYTES_PER_PIXEL: cfg_bpp_in  = csr_wdata[BPP_W-1:0];
            CSR_LINE_DATA_BYTES: cfg_len_in  = csr_wdata[LEN_W-1:0];
            CSR_ROW_TOTAL:       cfg_rows_in = csr_wdata[ROWS_W-1:0];
            default: ;
         endcase
      end

      if (accept) begin
         if (column_ff == '0) begin
            if (req_tdata > FILTER_LAST_CODE) begin
               halted_in           = 1'b1;
               s1_valid_in         = 1'b1;
               s1_byte_in          = '0;
               s1_x_in             = '0;
               s1_tag_in           = '0;
               s1_tag_in.err       = 1'b1;
            end else begin
               kind_in   = psu_filter_type'(req_tdata[2:0]);
               column_in = COLW'(1);
            end
         end else begin
            s1_valid_in         = 1'b1;
            s1_byte_in          = req_tdata;
            s1_x_in             = x_cur;
            s1_tag_in.err       = 1'b0;
            s1_tag_in.first_row = first_row_ff;
            s1_tag_in.row_end   = row_last;
            s1_tag_in.image_end = image_last;
            s1_tag_in.kind      = kind_ff;
            if (row_last) begin
               column_in = '0;
               if (image_last) begin
                  row_index_in = '0;
                  first_row_in = 1'b1;
               end else begin
                  row_index_in = row_index_ff + ROWS_W'(1);
                  first_row_in = 1'b0;
               end
            end else begin
               column_in = column_ff + COLW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_bpp_ff   <= BPP_W'(1);
         cfg_len_ff   <= LEN_W'(1);
         cfg_rows_ff  <= ROWS_W'(1);
         column_ff    <= '0;
         row_index_ff <= '0;
         first_row_ff <= 1'b1;
         halted_ff    <= 1'b0;
         kind_ff      <= FILTER_NONE;
         s1_valid_ff  <= 1'b0;
      end else begin
         cfg_bpp_ff   <= cfg_bpp_in;
         cfg_len_ff   <= cfg_len_in;
         cfg_rows_ff  <= cfg_rows_in;
         column_ff    <= column_in;
         row_index_ff <= row_index_in;
         first_row_ff <= first_row_in;
         halted_ff    <= halted_in;
         kind_ff      <= kind_in;
         s1_valid_ff  <= s1_valid_in;
      end
      s1_byte_ff <= s1_byte_in;
      s1_x_ff    <= s1_x_in;
      s1_tag_ff  <= s1_tag_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_byte  = s1_byte_ff;
   assign s1_x     = s1_x_ff;
   assign s1_tag   = s1_tag_ff;

endmodule

`default_nettype wire

>>> sv/psu_recon.sv
// Reconstruction stage: predictor (Sub/Up/Average/Paeth), line store write-back,
// left/upper-left byte history and the result register. Depends on psu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psu_recon #(
   parameter int MAX_ROW_BYTES   = 4096,
   parameter int MAX_PIXEL_BYTES = 8,
   localparam int XW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         s1_valid,
   input  wire logic [psu_pkg::BYTE_W-1:0]   s1_byte,
   input  wire logic [XW-1:0]                s1_x,
   input  wire psu_pkg::psu_tag_type         s1_tag,
   output logic                              s1_take,
   input  wire logic [psu_pkg::BPP_W-1:0]    bpp,
   input  wire logic [psu_pkg::BYTE_W-1:0]   rd_data,
   output logic                              wr_en,
   output logic      [XW-1:0]                wr_addr,
   output logic      [psu_pkg::BYTE_W-1:0]   wr_data,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [psu_pkg::BYTE_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   output logic      [psu_pkg::USER_W-1:0]   rsp_tuser
);

   import psu_pkg::*;

   // newest byte at index 0
   logic [BYTE_W-1:0] left_ff  [MAX_PIXEL_BYTES];
   logic [BYTE_W-1:0] upper_ff [MAX_PIXEL_BYTES];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff,  rsp_data_in;
   logic              rsp_last_ff,  rsp_last_in;
   logic [USER_W-1:0] rsp_user_ff,  rsp_user_in;

   logic [BYTE_W-1:0] a_raw, c_raw, a, b, c;
   logic              has_left;
   logic [BYTE_W:0]   avg_sum;
   logic signed [BYTE_W+1:0] pa, pb, pc;
   logic [BYTE_W-1:0] paeth;
   logic [BYTE_W-1:0] pred;
   logic [BYTE_W-1:0] val;

   always_comb begin
      a_raw = '0;
      c_raw = '0;
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
         if (bpp == BPP_W'(i + 1)) begin
            a_raw = left_ff[i];
            c_raw = upper_ff[i];
         end
      end
   end

   assign has_left = 32'(s1_x) >= 32'(bpp);
   assign a = has_left ? a_raw : '0;
   assign c = has_left ? c_raw : '0;
   assign b = s1_tag.first_row ? '0 : rd_data;

   // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
   always_comb begin
      pa = $signed({2'b00, b}) - $signed({2'b00, c});
      pb = $signed({2'b00, a}) - $signed({2'b00, c});
      pc = pa + pb;
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) begin
         paeth = a;
      end else if (pb <= pc) begin
         paeth = b;
      end else begin
         paeth = c;
      end
   end

   assign avg_sum = {1'b0, a} + {1'b0, b};

   always_comb begin
      unique case (s1_tag.kind)
         FILTER_SUB:     pred = a;
         FILTER_UP:      pred = b;
         FILTER_AVERAGE: pred = avg_sum[BYTE_W:1];
         FILTER_PAETH:   pred = paeth;
         default:        pred = '0;
      endcase
   end

   assign val     = s1_byte + pred;
   assign s1_take = s1_valid && (!rsp_valid_ff || rsp_tready);
   assign wr_en   = s1_take && !s1_tag.err;
   assign wr_addr = s1_x;
   assign wr_data = val;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      if (s1_take) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = '0;
         if (s1_tag.err) begin
            rsp_data_in              = '0;
            rsp_last_in              = 1'b0;
            rsp_user_in[USER_STATUS] = 1'b1;
         end else begin
            rsp_data_in                 = val;
            rsp_last_in                 = s1_tag.row_end;
            rsp_user_in[USER_IMAGE_END] = s1_tag.image_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
      if (wr_en) begin
         left_ff[0]  <= val;
         upper_ff[0] <= b;
         for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
            left_ff[i]  <= left_ff[i-1];
            upper_ff[i] <= upper_ff[i-1];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

>>> sv/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter: accept stage, line store, reconstruction.
// Depends on psu_pkg, psu_ctrl, psu_ram and psu_recon.
`timescale 1ns / 1ps
`default_nettype none

// One byte per clock, sustained, with rsp_tready high. A data byte is accepted,
// its column's entry of the previous row is read from the line store (one
// synchronous RAM, MAX_ROW_BYTES x 8) as the byte is loaded into the s1
// register at the accepting edge. The predictor then rebuilds the byte and,
// once the result register is free, writes it back at that column and loads it
// into the result register, which drives rsp_tvalid. Filter type bytes are
// taken and give no result; an invalid type gives one error result (status
// set) and every later byte is taken and dropped until reset. The line store
// is not cleared: rows must not grow longer than the row above within an image.
// The user writes registers only while the block is idle; nothing enforces it.
module png_scanline_unfilter #(
   parameter int MAX_ROW_BYTES   = 4096,
   parameter int MAX_PIXEL_BYTES = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [psu_pkg::CSR_AW-1:0]   csr_addr,
   input  wire logic [psu_pkg::CSR_DW-1:0]   csr_wdata,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [psu_pkg::BYTE_W-1:0]   req_tdata,   // [7:0] stream_byte
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [psu_pkg::BYTE_W-1:0]   rsp_tdata,   // [7:0] pixel_byte
   output logic                              rsp_tlast,   // row_end
   output logic      [psu_pkg::USER_W-1:0]   rsp_tuser    // [0] image_end, [1] status
);

   import psu_pkg::*;

   localparam int XW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

   logic              s1_valid;
   logic [BYTE_W-1:0] s1_byte;
   logic [XW-1:0]     s1_x;
   psu_tag_type       s1_tag;
   logic              s1_take;
   logic [BPP_W-1:0]  bpp;
   logic              rd_en;
   logic [XW-1:0]     rd_addr;
   logic [BYTE_W-1:0] rd_data;
   logic              wr_en;
   logic [XW-1:0]     wr_addr;
   logic [BYTE_W-1:0] wr_data;

   psu_ctrl #(
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .s1_valid   (s1_valid),
      .s1_byte    (s1_byte),
      .s1_x       (s1_x),
      .s1_tag     (s1_tag),
      .s1_take    (s1_take),
      .bpp        (bpp),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr)
   );

   psu_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_ROW_BYTES)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   psu_recon #(
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_recon (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1_byte    (s1_byte),
      .s1_x       (s1_x),
      .s1_tag     (s1_tag),
      .s1_take    (s1_take),
      .bpp        (bpp),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

>>> sv/psu_chk.sv
// Port-level checker for png_scanline_unfilter, bound to the top level.
// Depends on psu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psu_chk (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_tvalid,
   input wire logic                         rsp_tready,
   input wire logic [psu_pkg::BYTE_W-1:0]   rsp_tdata,
   input wire logic                         rsp_tlast,
   input wire logic [psu_pkg::USER_W-1:0]   rsp_tuser
);

   import psu_pkg::*;

   // nothing can be pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_STATUS] |->
         rsp_tdata == '0 && !rsp_tlast && !rsp_tuser[USER_IMAGE_END])
      else $error("error result carries data or flags");

   // error result is the last one until reset
   a_error_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser[USER_STATUS] |=> !rsp_tvalid)
      else $error("result after error transfer");

   a_image_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_IMAGE_END] |-> rsp_tlast)
      else $error("image end without row end");

endmodule

bind png_scanline_unfilter psu_chk u_psu_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

>>> tb/sv/tb_png_scanline_unfilter.sv
// Self-checking bench for png_scanline_unfilter: directed and random PNG byte streams,
// every rebuilt byte predicted in the bench and compared in order with the result stream.
// Needs psu_pkg and the unfilter RTL; nothing else.
`timescale 1ns / 1ps

module tb_png_scanline_unfilter;
   import psu_pkg::*;

   localparam int LINE_CAP  = 4096;
   localparam int PIXEL_CAP = 8;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [7:0] pixel;
      logic       row_end;
      logic       image_end;
      logic       status;
   } rebuilt_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic [CSR_AW-1:0]   csr_addr = '0;
   logic [CSR_DW-1:0]   csr_wdata = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [BYTE_W-1:0]   req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [BYTE_W-1:0]   rsp_tdata;
   logic                rsp_tlast;
   logic [USER_W-1:0]   rsp_tuser;

   png_scanline_unfilter #(
      .MAX_ROW_BYTES(LINE_CAP),
      .MAX_PIXEL_BYTES(PIXEL_CAP)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   always #2 clock = ~clock;

   // register copies, as written
   logic [3:0]  cfg_bpp = 4'd1;
   logic [12:0] cfg_len = 13'd1;
   logic [30:0] cfg_rows = 31'd1;

   // unfilter state as the bench sees it
   logic [7:0]     prev_row [0:LINE_CAP-1];
   logic [63:0]    left_hist = '0;
   logic [63:0]    upleft_hist = '0;
   int             pos_col = 0;
   int             row_num = 0;
   psu_filter_type cur_kind = FILTER_NONE;
   logic           top_row = 1'b1;
   logic           stopped = 1'b0;

   // stream generator position, kept ahead of the predictor
   int gen_col = 0;
   int gen_row = 0;

   logic [7:0]  byte_feed [$];
   rebuilt_type rebuilt_q [$];
   int          items_queued = 0;
   int          items_taken = 0;
   int          failures = 0;
   logic        in_fire = 1'b0;
   logic        feed_paused = 1'b0;
   int          send_idle_pct = 25;
   int          recv_idle_pct = 75;
   int          hold_request = 0;
   int          hold_served = 0;
   int          hold_left = 0;

   function automatic int eff_len();
      if (cfg_len == 0) return 1;
      if (cfg_len > LINE_CAP) return LINE_CAP;
      return int'(cfg_len);
   endfunction

   function automatic int eff_rows();
      return (cfg_rows == 0) ? 1 : int'(cfg_rows);
   endfunction

   task automatic rebuild_byte(input logic [7:0] sb);
      int bpp, x, p, pa, pb, pc;
      logic [7:0] a, b, c, pred, val;
      logic row_last, img_last;
      rebuilt_type r;
      if (stopped) return;
      bpp = (cfg_bpp == 0) ? 1 : ((cfg_bpp > PIXEL_CAP) ? PIXEL_CAP : int'(cfg_bpp));
      if (pos_col == 0) begin
         if (sb > FILTER_LAST_CODE) begin
            stopped = 1'b1;
            r.pixel = 8'h00;
            r.row_end = 1'b0;
            r.image_end = 1'b0;
            r.status = 1'b1;
            rebuilt_q.push_back(r);
         end else begin
            cur_kind = psu_filter_type'(sb[2:0]);
            left_hist = '0;
            upleft_hist = '0;
            pos_col = 1;
         end
         return;
      end
      x = (pos_col - 1 >= LINE_CAP) ? LINE_CAP - 1 : pos_col - 1;
      a = (x >= bpp) ? left_hist[8*(bpp-1) +: 8] : 8'h00;
      b = top_row ? 8'h00 : prev_row[x];
      c = (x >= bpp) ? upleft_hist[8*(bpp-1) +: 8] : 8'h00;
      case (cur_kind)
         FILTER_SUB:     pred = a;
         FILTER_UP:      pred = b;
         FILTER_AVERAGE: pred = 8'((int'(a) + int'(b)) / 2);
         FILTER_PAETH: begin
            p = int'(a) + int'(b) - int'(c);
            pa = (p >= int'(a)) ? p - int'(a) : int'(a) - p;
            pb = (p >= int'(b)) ? p - int'(b) : int'(b) - p;
            pc = (p >= int'(c)) ? p - int'(c) : int'(c) - p;
            if (pa <= pb && pa <= pc) pred = a;
            else if (pb <= pc) pred = b;
            else pred = c;
         end
         default:        pred = 8'h00;
      endcase
      val = sb + pred;
      prev_row[x] = val;
      left_hist = {left_hist[55:0], val};
      upleft_hist = {upleft_hist[55:0], b};
      row_last = (x + 1 >= eff_len());
      img_last = row_last && (row_num + 1 >= eff_rows());
      if (row_last) begin
         pos_col = 0;
         if (img_last) begin
            row_num = 0;
            top_row = 1'b1;
         end else begin
            row_num = row_num + 1;
            top_row = 1'b0;
         end
      end else begin
         pos_col = pos_col + 1;
      end
      r.pixel = val;
      r.row_end = row_last;
      r.image_end = img_last;
      r.status = 1'b0;
      rebuilt_q.push_back(r);
   endtask

   task automatic note_field(input string what, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         failures++;
         if (failures <= 200)
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
   endtask

   // monitor: result check first, then the input transfer feeds the predictor
   always @(posedge clock) begin
      rebuilt_type want;
      in_fire = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (rebuilt_q.size() == 0) begin
               failures++;
               if (failures <= 200)
                  $display("%0t ns: unexpected result, expected none, actual %h/%b/%b",
                           $time, rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               want = rebuilt_q.pop_front();
               note_field("pixel_byte", want.pixel, rsp_tdata);
               note_field("row_end", {7'd0, want.row_end}, {7'd0, rsp_tlast});
               note_field("image_end", {7'd0, want.image_end}, {7'd0, rsp_tuser[USER_IMAGE_END]});
               note_field("status", {7'd0, want.status}, {7'd0, rsp_tuser[USER_STATUS]});
            end
         end
         if (req_tvalid && req_tready) begin
            in_fire = 1'b1;
            items_taken++;
            rebuild_byte(req_tdata);
         end
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || in_fire) begin
         if (byte_feed.size() != 0 && !feed_paused && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= byte_feed.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver, with an occasional long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_request) begin
         hold_served = hold_request;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic csr_write(input logic [CSR_AW-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value[CSR_DW-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BYTES_PER_PIXEL: cfg_bpp = value[3:0];
         CSR_LINE_DATA_BYTES: cfg_len = value[12:0];
         CSR_ROW_TOTAL:       cfg_rows = value[30:0];
         default: ;
      endcase
   endtask

   task automatic push_one(input logic [7:0] sb);
      byte_feed.push_back(sb);
      items_queued++;
      if (gen_col == 0) begin
         gen_col = 1;
      end else if (gen_col >= eff_len()) begin
         gen_col = 0;
         gen_row = (gen_row + 1 >= eff_rows()) ? 0 : gen_row + 1;
      end else begin
         gen_col++;
      end
   endtask

   function automatic logic [7:0] rand_byte();
      if (gen_col == 0) return 8'($urandom_range(FILTER_LAST_CODE));
      case ($urandom_range(19))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic push_bytes(input int n);
      repeat (n) push_one(rand_byte());
   endtask

   // at least one byte, then up to the end of the current image
   task automatic push_image();
      push_one(rand_byte());
      while (gen_col != 0 || gen_row != 0) push_one(rand_byte());
   endtask

   // idle once every transfer is back, plus room for a trailing filter byte
   task automatic wait_drained();
      while (items_taken != items_queued || rebuilt_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      int rand_start, done, pick, n, pressure_mark;
      logic [7:0] directed_seq [24];
      directed_seq = '{
         8'(FILTER_NONE), 8'hff,
         8'(FILTER_SUB), 8'h00,
         8'(FILTER_SUB), 8'h00, 8'hff, 8'h80, 8'h7f,
         8'(FILTER_UP), 8'hff, 8'h01, 8'h00, 8'hff,
         8'(FILTER_AVERAGE), 8'h10, 8'hfe, 8'h01, 8'h80,
         8'(FILTER_PAETH), 8'h00, 8'h33, 8'hff, 8'hc4
      };
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // two one-byte images at the reset settings, then one of each filter
      for (int i = 0; i < 4; i++) push_one(directed_seq[i]);
      wait_drained();
      csr_write(CSR_BYTES_PER_PIXEL, 2);
      csr_write(CSR_LINE_DATA_BYTES, 4);
      csr_write(CSR_ROW_TOTAL, 4);
      for (int i = 4; i < 24; i++) push_one(directed_seq[i]);
      wait_drained();

      // register extremes, including values that get clamped
      csr_write(CSR_BYTES_PER_PIXEL, 8);
      csr_write(CSR_LINE_DATA_BYTES, 16);
      csr_write(CSR_ROW_TOTAL, 3);
      push_image();
      wait_drained();
      csr_write(CSR_BYTES_PER_PIXEL, 0);
      csr_write(CSR_LINE_DATA_BYTES, 0);
      csr_write(CSR_ROW_TOTAL, 0);
      push_bytes(6);
      wait_drained();
      csr_write(CSR_BYTES_PER_PIXEL, 15);
      csr_write(CSR_LINE_DATA_BYTES, 20);
      csr_write(CSR_ROW_TOTAL, 2);
      push_image();
      wait_drained();

      // writes in the middle of a row and of an image
      csr_write(CSR_BYTES_PER_PIXEL, 4);
      csr_write(CSR_LINE_DATA_BYTES, 12);
      csr_write(CSR_ROW_TOTAL, 31'h7fff_ffff);
      push_bytes(45);
      wait_drained();
      csr_write(CSR_LINE_DATA_BYTES, 3);   // column already past it: row ends on next byte
      push_bytes(9);
      wait_drained();
      csr_write(CSR_ROW_TOTAL, 1);
      csr_write(CSR_BYTES_PER_PIXEL, 1);
      push_image();
      wait_drained();

      rand_start = items_queued;
      while (items_queued - rand_start < 1000) begin
         done = items_queued - rand_start;
         if (done < 333) begin
            send_idle_pct = 25;
            recv_idle_pct = 75;
         end else if (done < 666) begin
            send_idle_pct = 75;
            recv_idle_pct = 25;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         csr_write(CSR_BYTES_PER_PIXEL,
                   ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8, 1));
         pick = $urandom_range(99);
         csr_write(CSR_LINE_DATA_BYTES,
                   (pick < 3) ? 0 : (pick < 80) ? $urandom_range(24, 1) :
                   (pick < 97) ? $urandom_range(200, 25) : $urandom_range(600, 201));
         csr_write(CSR_ROW_TOTAL, ($urandom_range(19) == 0) ? 0 : $urandom_range(5, 1));
         repeat ($urandom_range(2, 1)) push_image();
         if ($urandom_range(99) < 35) begin
            push_bytes($urandom_range(eff_len() + 3, 1));
            wait_drained();
            case ($urandom_range(2))
               0: csr_write(CSR_BYTES_PER_PIXEL, $urandom_range(8, 1));
               1: csr_write(CSR_LINE_DATA_BYTES, $urandom_range(eff_len(), 1));   // shrink only
               default: csr_write(CSR_ROW_TOTAL, $urandom_range(4, 1));
            endcase
            push_image();
         end
         wait_drained();
      end

      // back-pressure: receiver stalls long while bytes keep coming, then a sender pause
      csr_write(CSR_BYTES_PER_PIXEL, 4);
      csr_write(CSR_LINE_DATA_BYTES, 64);
      csr_write(CSR_ROW_TOTAL, 5);
      pressure_mark = items_taken;
      push_image();
      hold_request++;
      while (items_taken < pressure_mark + 200) @(negedge clock);
      feed_paused = 1'b1;
      while (req_tvalid || rebuilt_q.size() != 0) @(negedge clock);
      feed_paused = 1'b0;
      wait_drained();

      // over-long row setting is clamped; a shrink then ends the row on the next byte
      csr_write(CSR_BYTES_PER_PIXEL, 3);
      csr_write(CSR_LINE_DATA_BYTES, 13'h1fff);
      csr_write(CSR_ROW_TOTAL, 2);
      push_bytes(201);
      wait_drained();
      csr_write(CSR_LINE_DATA_BYTES, 5);
      push_image();
      wait_drained();

      // bad filter type halts the block; the trailing bytes must be dropped
      push_one(8'($urandom_range(255, 5)));
      push_bytes(6);

      n = 0;
      while ((items_taken != items_queued || rebuilt_q.size() != 0) && n < 100000) begin
         @(negedge clock);
         n++;
      end
      repeat (16) @(negedge clock);
      if (rebuilt_q.size() != 0) begin
         failures += rebuilt_q.size();
         $display("%0t ns: %0d expected results never arrived", $time, rebuilt_q.size());
      end
      if (failures == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
